@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define TCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcce assertion failed");

// next-cycle implication, off while in reset
`define TCCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcce assertion failed");

`endif

@@ rtl/tcce_pkg.sv @@
`default_nettype none
package tcce_pkg;

  localparam int ROWS_DEF      = 25;
  localparam int COLS_DEF      = 80;
  localparam int FIRST_ROW_DEF = 0;
  localparam int FIRST_COL_DEF = 0;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 1'd1;

  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'd15;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'd0;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int TAB_SHIFT = 3;  // tab stops every 8 columns

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_COPY  = 5'b01000,
    S_BLANK = 5'b10000
  } state_e;

  // cursor update request from the sequencer
  typedef struct packed {
    logic ctrl;   // apply control character
    logic home;   // form feed home
    logic prep;   // wrap and park on last row before scroll
    logic put;    // printable written, advance
  } cur_cmd_t;

endpackage
`default_nettype wire

@@ rtl/tcce_cell_ram.sv @@
`default_nettype none
module tcce_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int DW    = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcce_cursor.sv @@
`default_nettype none
module tcce_cursor #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int FIRST_ROW = 0,
  parameter int FIRST_COL = 0,
  localparam int AW       = $clog2(ROWS * COLS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tcce_pkg::cur_cmd_t     cmd_i,
  input  wire logic [7:0]             char_i,
  output logic                        need_scroll_o,
  output logic [AW-1:0]               cell_addr_o,
  output logic [tcce_pkg::POS_W-1:0]  pos_o
);
  import tcce_pkg::*;

  localparam int RW = $clog2(ROWS + 1);
  localparam int CW = $clog2(COLS + 1);
  localparam int PW = (RW + CW > POS_W) ? RW + CW : POS_W;

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW:0]   row_w;
  logic [CW-1:0] col_w;
  logic [CW:0]   col_tab;
  logic [PW-1:0] addr_full, pos_full;

  // pending wrap resolves onto the next row
  always_comb begin
    if (col_q >= CW'(COLS)) begin
      col_w = CW'(FIRST_COL);
      row_w = (RW+1)'(row_q) + (RW+1)'(1);
    end else begin
      col_w = col_q;
      row_w = (RW+1)'(row_q);
    end
  end

  assign need_scroll_o = row_w >= (RW+1)'(ROWS);
  assign addr_full     = PW'(row_w) * PW'(COLS) + PW'(col_w);
  assign cell_addr_o   = addr_full[AW-1:0];
  assign pos_full      = PW'(row_q) * PW'(COLS) + PW'(col_q);
  assign pos_o         = pos_full[POS_W-1:0];

  assign col_tab = (((CW+1)'(col_q) >> TAB_SHIFT) + (CW+1)'(1)) << TAB_SHIFT;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.home) begin
      row_d = RW'(FIRST_ROW);
      col_d = CW'(FIRST_COL);
    end else if (cmd_i.prep) begin
      row_d = RW'(ROWS - 1);
      col_d = col_w;
    end else if (cmd_i.put) begin
      row_d = row_w[RW-1:0];
      col_d = col_w + CW'(1);
    end else if (cmd_i.ctrl) begin
      case (char_i)
        CH_BS: begin
          if (col_q > CW'(FIRST_COL)) begin
            col_d = col_q - CW'(1);
          end else if (row_q > RW'(FIRST_ROW)) begin
            col_d = CW'(COLS - 1);
            row_d = row_q - RW'(1);
          end
        end
        CH_TAB: begin
          if (col_tab > (CW+1)'(COLS - 1)) begin
            col_d = CW'(COLS - 1);
          end else begin
            col_d = col_tab[CW-1:0];
          end
        end
        CH_LF: begin
          if (row_q < RW'(ROWS)) begin
            row_d = row_q + RW'(1);
          end
          col_d = CW'(FIRST_COL);
        end
        CH_CR: begin
          col_d = CW'(FIRST_COL);
        end
        default: begin
          row_d = row_q;
          col_d = col_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= RW'(FIRST_ROW);
      col_q <= CW'(FIRST_COL);
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcce_seq.sv @@
`default_nettype none
module tcce_seq #(
  parameter int ROWS      = 25,
  parameter int COLS      = 80,
  parameter int FIRST_ROW = 0,
  localparam int AW       = $clog2(ROWS * COLS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]   char_code_i,
  input  wire logic [tcce_pkg::IDX_W-1:0]    cell_index_i,
  input  wire logic                          out_free_i,
  output logic                               load_o,
  output logic [tcce_pkg::CELL_W-1:0]        load_data_o,
  input  wire logic [tcce_pkg::ATTR_W-1:0]   text_attr_i,
  input  wire logic [tcce_pkg::ATTR_W-1:0]   blank_attr_i,
  output tcce_pkg::cur_cmd_t                 cmd_o,
  output logic [tcce_pkg::CHAR_W-1:0]        cmd_char_o,
  input  wire logic                          need_scroll_i,
  input  wire logic [AW-1:0]                 cell_addr_i,
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output logic [tcce_pkg::CELL_W-1:0]        ram_wdata_o,
  output logic                               ram_re_o,
  output logic [AW-1:0]                      ram_raddr_o,
  input  wire logic [tcce_pkg::CELL_W-1:0]   ram_rdata_i
);
  import tcce_pkg::*;

  localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [AW:0]   CellCount = (AW+1)'(ROWS * COLS);
  localparam logic [AW-1:0] LastCell  = AW'(ROWS * COLS - 1);
  localparam logic [AW:0]   CopySrc   = (AW+1)'((FIRST_ROW + 1) * COLS);
  localparam logic [AW-1:0] CopyDst   = AW'(FIRST_ROW * COLS);
  localparam logic [AW-1:0] LastRow   = AW'((ROWS - 1) * COLS);

  state_e              state_q, state_d;
  logic                func_q;
  logic [CHAR_W-1:0]   char_q;
  logic                hit_q, hit;
  logic [AW:0]         rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic                cp_v_q, cp_v_d;
  logic [AW-1:0]       blk_ptr_q, blk_ptr_d;
  logic [IW-1:0]       idx_x;
  logic                accept, issue;

  assign in_stall_o = !((state_q == S_IDLE) && out_free_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_x      = IW'(cell_index_i);
  assign hit        = idx_x < IW'(ROWS * COLS);
  assign issue      = rd_ptr_q < CellCount;
  assign cmd_char_o = char_q;

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cp_v_d      = 1'b0;
    blk_ptr_d   = blk_ptr_q;
    load_o      = 1'b0;
    load_data_o = '0;
    cmd_o       = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = blk_ptr_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_x[AW-1:0];
    case (state_q)
      S_INIT: begin
        ram_we_o  = 1'b1;
        blk_ptr_d = blk_ptr_q + AW'(1);
        if (blk_ptr_q == LastCell) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ram_re_o = (func_i == FUNC_READ) && hit;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_q == FUNC_READ) begin
          load_o      = 1'b1;
          load_data_o = hit_q ? ram_rdata_i : '0;
          state_d     = S_IDLE;
        end else begin
          case (char_q)
            CH_BS, CH_TAB, CH_LF, CH_CR: begin
              cmd_o.ctrl = 1'b1;
              load_o     = 1'b1;
              state_d    = S_IDLE;
            end
            CH_FF: begin
              cmd_o.home = 1'b1;
              blk_ptr_d  = '0;
              state_d    = S_BLANK;
            end
            default: begin
              if (need_scroll_i) begin
                cmd_o.prep = 1'b1;
                rd_ptr_d   = CopySrc;
                wr_ptr_d   = CopyDst;
                state_d    = S_COPY;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = cell_addr_i;
                ram_wdata_o = {text_attr_i, char_q};
                cmd_o.put   = 1'b1;
                load_o      = 1'b1;
                state_d     = S_IDLE;
              end
            end
          endcase
        end
      end
      S_COPY: begin
        // read runs one row ahead of the write; cp_v_q marks a registered read word to write
        ram_re_o    = issue;
        ram_raddr_o = rd_ptr_q[AW-1:0];
        cp_v_d      = issue;
        if (issue) begin
          rd_ptr_d = rd_ptr_q + (AW+1)'(1);
        end
        ram_waddr_o = wr_ptr_q;
        ram_wdata_o = ram_rdata_i;
        if (cp_v_q) begin
          ram_we_o = 1'b1;
          wr_ptr_d = wr_ptr_q + AW'(1);
        end
        if (!issue && !cp_v_q) begin
          blk_ptr_d = LastRow;
          state_d   = S_BLANK;
        end
      end
      S_BLANK: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = {blank_attr_i, CH_SPACE};
        blk_ptr_d   = blk_ptr_q + AW'(1);
        if (blk_ptr_q == LastCell) begin
          if (char_q == CH_FF) begin
            load_o  = 1'b1;
            state_d = S_IDLE;
          end else begin
            // scroll done, write the pending character
            state_d = S_EXEC;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cp_v_q    <= 1'b0;
      blk_ptr_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cp_v_q    <= cp_v_d;
      blk_ptr_q <= blk_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      char_q <= char_code_i;
      hit_q  <= hit;
    end
  end

endmodule
`default_nettype wire

@@ rtl/text_console_character_engine_unit.sv @@
// a read or a control character loads its word from S_EXEC into the output register;
//   no new word is taken until the engine is back in S_IDLE; a printable character is
//   written from S_EXEC, or after a copy and blank through the cell ram when it scrolls
// form feed blanks the whole cell ram one cell a cycle
// reset: cursor homes, attributes take 15 and 0, then a clearing pass
//   zeroes the cell ram with in_stall_o high; config writes are taken meanwhile
`default_nettype none
`include "assert_macros.svh"
module text_console_character_engine_unit #(
  parameter int ROWS      = tcce_pkg::ROWS_DEF,
  parameter int COLS      = tcce_pkg::COLS_DEF,
  parameter int FIRST_ROW = tcce_pkg::FIRST_ROW_DEF,
  parameter int FIRST_COL = tcce_pkg::FIRST_COL_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              func_i,
  input  wire logic [tcce_pkg::CHAR_W-1:0]       char_code_i,
  input  wire logic [tcce_pkg::IDX_W-1:0]        cell_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [tcce_pkg::POS_W-1:0]             cursor_position_o,
  output logic [tcce_pkg::CELL_W-1:0]            cell_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import tcce_pkg::*;

  localparam int AW = $clog2(ROWS * COLS);

  logic [ATTR_W-1:0] text_attr_q, blank_attr_q;
  logic              out_valid_q, out_valid_d;
  logic [CELL_W-1:0] cell_data_q;
  logic              out_free;
  logic              load;
  logic [CELL_W-1:0] load_data;
  cur_cmd_t          cmd;
  logic [CHAR_W-1:0] cmd_char;
  logic              need_scroll;
  logic [AW-1:0]     cell_addr;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= TEXT_ATTR_RST;
      blank_attr_q <= BLANK_ATTR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEXT_ATTR:  text_attr_q  <= cfg_wdata_i[ATTR_W-1:0];
        CFG_BLANK_ATTR: blank_attr_q <= cfg_wdata_i[ATTR_W-1:0];
        default: begin
          text_attr_q  <= text_attr_q;
          blank_attr_q <= blank_attr_q;
        end
      endcase
    end
  end

  // output word register; cursor holds still until the next word is taken
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cell_data_q <= load_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_data_o = cell_data_q;

  tcce_seq #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .FIRST_ROW (FIRST_ROW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_free_i   (out_free),
    .load_o       (load),
    .load_data_o  (load_data),
    .text_attr_i  (text_attr_q),
    .blank_attr_i (blank_attr_q),
    .cmd_o        (cmd),
    .cmd_char_o   (cmd_char),
    .need_scroll_i(need_scroll),
    .cell_addr_i  (cell_addr),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tcce_cursor #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .FIRST_ROW (FIRST_ROW),
    .FIRST_COL (FIRST_COL)
  ) u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .char_i       (cmd_char),
    .need_scroll_o(need_scroll),
    .cell_addr_o  (cell_addr),
    .pos_o        (cursor_position_o)
  );

  tcce_cell_ram #(
    .DEPTH (ROWS * COLS),
    .DW    (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // a word is only taken once the output register is free
  `TCCE_ASSERT_IMP(a_take_needs_room, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o || !out_stall_i)
  // no result shows up in the cycle right after a word is taken
  `TCCE_ASSERT_NXT(a_no_early_result, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o)
  // text attribute write lands
  `TCCE_ASSERT_NXT(a_cfg_text, clk_i, rst_ni, cfg_we_i && (cfg_idx_i == CFG_TEXT_ATTR), text_attr_q == $past(cfg_wdata_i[ATTR_W-1:0]))

endmodule
`default_nettype wire
